FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the stack block checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle
`define ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle
`define ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bstk_pkg.sv
// ----------------------------------------------------------------------------
// bstk_pkg
// Widths, codes and controller/datapath bundle types for the bounded stack.
// ----------------------------------------------------------------------------
`default_nettype none

package bstk_pkg;

  // Field widths
  localparam int OpW    = 2;
  localparam int ValueW = 32;
  localparam int PosW   = 5;
  localparam int CountW = 5;
  localparam int StatW  = 2;

  // Default stack depth
  localparam int DepthDefault = 16;

  // Operation codes
  localparam logic [OpW-1:0] OpPush   = 2'd0;
  localparam logic [OpW-1:0] OpPop    = 2'd1;
  localparam logic [OpW-1:0] OpRemove = 2'd2;

  // Status codes
  localparam logic [StatW-1:0] StOk        = 2'd0;
  localparam logic [StatW-1:0] StOverflow  = 2'd1;
  localparam logic [StatW-1:0] StUnderflow = 2'd2;
  localparam logic [StatW-1:0] StBadPos    = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic             capture;   // latch status, clear removed word
    logic [StatW-1:0] status;
    logic             push;      // write top slot, count up
    logic             rd_top;    // read top slot, count down
    logic             rd_pos;    // read slot at position, arm shift pointer
    logic             take;      // latch read word as removed word
    logic             shift_rd;  // read next slot above the gap
    logic             cnt_dec;   // count down at end of remove
    logic             load_out;  // load output register
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic pos_bad;
    logic shift_more;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/bstk_ifs.sv
// ----------------------------------------------------------------------------
// bstk_ifs
// Valid/ready channel interfaces for stack requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface bstk_req_if;
  logic                                 valid;
  logic                                 ready;
  logic        [bstk_pkg::OpW-1:0]      operation;
  logic signed [bstk_pkg::ValueW-1:0]   value;
  logic        [bstk_pkg::PosW-1:0]     position;

  modport source (output valid, output operation, output value, output position,
                  input ready);
  modport sink   (input valid, input operation, input value, input position,
                  output ready);
endinterface

interface bstk_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bstk_pkg::ValueW-1:0]   removed_value;
  logic        [bstk_pkg::StatW-1:0]    status;
  logic                                 is_full;
  logic                                 is_empty;
  logic        [bstk_pkg::CountW-1:0]   count;

  modport source (output valid, output removed_value, output status,
                  output is_full, output is_empty, output count, input ready);
  modport sink   (input valid, input removed_value, input status,
                  input is_full, input is_empty, input count, output ready);
endinterface

`default_nettype wire

FILE: rtl/bstk_ctrl.sv
// ----------------------------------------------------------------------------
// bstk_ctrl
// Sequencer: decodes a request, drives reads, the shift walk and the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bstk_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic [bstk_pkg::OpW-1:0]   op_i,
  output logic                            in_ready_o,
  input  wire bstk_pkg::dp_sts_t          sts_i,
  output bstk_pkg::dp_cmd_t               cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_TAKE  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       rem_q, rem_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Decode and sequence
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    rem_d   = rem_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          cmd_o.status  = bstk_pkg::StOk;
          state_d       = S_DONE;
          rem_d         = 1'b0;
          case (op_i)
            bstk_pkg::OpPush: begin
              if (sts_i.full) begin
                cmd_o.status = bstk_pkg::StOverflow;
              end else begin
                cmd_o.push = 1'b1;
              end
            end
            bstk_pkg::OpPop: begin
              if (sts_i.empty) begin
                cmd_o.status = bstk_pkg::StUnderflow;
              end else begin
                cmd_o.rd_top = 1'b1;
                state_d      = S_TAKE;
              end
            end
            bstk_pkg::OpRemove: begin
              if (sts_i.empty) begin
                cmd_o.status = bstk_pkg::StUnderflow;
              end else if (sts_i.pos_bad) begin
                cmd_o.status = bstk_pkg::StBadPos;
              end else begin
                cmd_o.rd_pos = 1'b1;
                rem_d        = 1'b1;
                state_d      = S_TAKE;
              end
            end
            default: ;
          endcase
        end
      end
      S_TAKE: begin
        cmd_o.take = 1'b1;
        state_d    = rem_q ? S_SHIFT : S_DONE;
      end
      S_SHIFT: begin
        if (sts_i.shift_more) begin
          cmd_o.shift_rd = 1'b1;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rem_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bstk_dpath.sv
// ----------------------------------------------------------------------------
// bstk_dpath
// Entry memory, fill count, shift pointer and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bstk_dpath #(
  parameter int DEPTH = bstk_pkg::DepthDefault
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire bstk_pkg::dp_cmd_t                  cmd_i,
  output bstk_pkg::dp_sts_t                       sts_o,
  input  wire logic signed [bstk_pkg::ValueW-1:0] value_i,
  input  wire logic [bstk_pkg::PosW-1:0]          position_i,
  input  wire logic                               out_ready_i,
  output logic                                    out_valid_o,
  output logic signed [bstk_pkg::ValueW-1:0]      removed_value_o,
  output logic [bstk_pkg::StatW-1:0]              status_o,
  output logic                                    is_full_o,
  output logic                                    is_empty_o,
  output logic [bstk_pkg::CountW-1:0]             count_o
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int AW   = $clog2(DEPTH);
  localparam int ExtW = (CntW > bstk_pkg::PosW) ? CntW : bstk_pkg::PosW;
  localparam int VW   = bstk_pkg::ValueW;

  logic [VW-1:0]   mem [DEPTH];
  logic [VW-1:0]   rd_data_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] rptr_q;
  logic            wr_pend_q;
  logic [AW-1:0]   wr_addr_q;
  logic [VW-1:0]   taken_q;
  logic [1:0]      status_q;
  logic            out_valid_q;

  logic [ExtW-1:0] cnt_ext, pos_ext, pos_m1;
  logic [CntW-1:0] cnt_m1, rptr_m1;
  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [VW-1:0]   wr_data;
  logic            full, empty;

  // Common compares
  assign cnt_ext = ExtW'(count_q);
  assign pos_ext = ExtW'(position_i);
  assign pos_m1  = pos_ext - 1'b1;
  assign cnt_m1  = count_q - 1'b1;
  assign rptr_m1 = rptr_q - 1'b1;
  assign empty   = (count_q == '0);
  assign full    = (count_q == CntW'(DEPTH));

  assign sts_o.empty      = empty;
  assign sts_o.full       = full;
  assign sts_o.pos_bad    = (pos_ext == '0) || (pos_ext > cnt_ext);
  assign sts_o.shift_more = (rptr_q < count_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // Select memory port addresses
  assign rd_en   = cmd_i.rd_top || cmd_i.rd_pos || cmd_i.shift_rd;
  assign rd_addr = cmd_i.rd_top ? cnt_m1[AW-1:0] :
                   cmd_i.rd_pos ? pos_m1[AW-1:0] : rptr_q[AW-1:0];
  assign wr_en   = cmd_i.push || wr_pend_q;
  assign wr_addr = cmd_i.push ? count_q[AW-1:0] : wr_addr_q;
  assign wr_data = cmd_i.push ? value_i : rd_data_q;

  // Entry memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Count, shift pointer, pending write, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rptr_q      <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.push) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.rd_top || cmd_i.cnt_dec) begin
        count_q <= cnt_m1;
      end
      if (cmd_i.rd_pos) begin
        rptr_q <= pos_ext[CntW-1:0];
      end else if (cmd_i.shift_rd) begin
        rptr_q <= rptr_q + 1'b1;
      end
      wr_pend_q <= cmd_i.shift_rd;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold shift target, status and removed word; load result
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_rd) begin
      wr_addr_q <= rptr_m1[AW-1:0];
    end
    if (cmd_i.capture) begin
      status_q <= cmd_i.status;
      taken_q  <= '0;
    end else if (cmd_i.take) begin
      taken_q <= rd_data_q;
    end
    if (cmd_i.load_out) begin
      removed_value_o <= taken_q;
      status_o        <= status_q;
      is_full_o       <= full;
      is_empty_o      <= empty;
      count_o         <= cnt_ext[bstk_pkg::CountW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/bounded_stack_with_remove_at.sv
// ----------------------------------------------------------------------------
// bounded_stack_with_remove_at
// Bounded LIFO stack of signed words with push, pop and remove-at-position.
// ----------------------------------------------------------------------------
// One request is handled at a time; the response sits in an output register,
// so the next request is taken as soon as the response is loaded. A push or
// refused request decodes, then loads; a pop reads the top, takes the word and
// loads; a remove at p reads slot p, takes it, runs the shift walk moving one
// entry a cycle down through the entry memory (one read and one write a cycle),
// counts down and loads. Positions count from 1 at the bottom; on a non-empty
// stack, position zero or above the count gets bad-position status, no change.
`default_nettype none

module bounded_stack_with_remove_at #(
  parameter int DEPTH = bstk_pkg::DepthDefault
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bstk_req_if.sink    req_i,
  bstk_rsp_if.source  rsp_o
);

  bstk_pkg::dp_cmd_t cmd;
  bstk_pkg::dp_sts_t sts;

  // Sequencer
  bstk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .op_i       (req_i.operation),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage and result path
  bstk_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .value_i         (req_i.value),
    .position_i      (req_i.position),
    .out_ready_i     (rsp_o.ready),
    .out_valid_o     (rsp_o.valid),
    .removed_value_o (rsp_o.removed_value),
    .status_o        (rsp_o.status),
    .is_full_o       (rsp_o.is_full),
    .is_empty_o      (rsp_o.is_empty),
    .count_o         (rsp_o.count)
  );

endmodule

`default_nettype wire

FILE: rtl/bstk_chk.sv
// ----------------------------------------------------------------------------
// bstk_chk
// Port-level checks for the bounded stack, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bstk_chk (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              req_valid_i,
  input wire logic                              req_ready_i,
  input wire logic                              rsp_valid_i,
  input wire logic                              rsp_ready_i,
  input wire logic [bstk_pkg::ValueW-1:0]       rsp_removed_value_i,
  input wire logic [bstk_pkg::StatW-1:0]        rsp_status_i,
  input wire logic                              rsp_is_full_i,
  input wire logic                              rsp_is_empty_i,
  input wire logic [bstk_pkg::CountW-1:0]       rsp_count_i
);

  // Stalled response holds
  `ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i,
               rsp_valid_i && $stable(rsp_removed_value_i) && $stable(rsp_status_i),
               "response changed while stalled")

  // One request in flight: ready drops after a request
  `ASSERT_NEXT(a_one_inflight, clk_i, rst_ni, req_valid_i && req_ready_i,
               !req_ready_i, "request taken while another is in flight")

  // A refused request returns no word
  `ASSERT_IMPL(a_no_word_on_err, clk_i, rst_ni,
               rsp_valid_i && (rsp_status_i != bstk_pkg::StOk),
               rsp_removed_value_i == '0, "word returned with error status")

  // Overflow only when full, underflow only when empty
  `ASSERT_IMPL(a_err_flags, clk_i, rst_ni, rsp_valid_i,
               ((rsp_status_i != bstk_pkg::StOverflow) || rsp_is_full_i) &&
               ((rsp_status_i != bstk_pkg::StUnderflow) || rsp_is_empty_i),
               "error status disagrees with flags")

  // Empty flag tracks count
  `ASSERT_IMPL(a_empty_count, clk_i, rst_ni, rsp_valid_i,
               rsp_is_empty_i == (rsp_count_i == '0), "empty flag disagrees with count")

endmodule

bind bounded_stack_with_remove_at bstk_chk u_bstk_chk (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .req_valid_i         (req_i.valid),
  .req_ready_i         (req_i.ready),
  .rsp_valid_i         (rsp_o.valid),
  .rsp_ready_i         (rsp_o.ready),
  .rsp_removed_value_i (rsp_o.removed_value),
  .rsp_status_i        (rsp_o.status),
  .rsp_is_full_i       (rsp_o.is_full),
  .rsp_is_empty_i      (rsp_o.is_empty),
  .rsp_count_i         (rsp_o.count)
);

`default_nettype wire

FILE: dv/tb_bounded_stack_with_remove_at.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_stack_with_remove_at
// Self-checking bench for the bounded stack. A shadow stack predicts status,
// removed word, flags and count for every accepted request. Responses are
// compared in order. Stimulus starts with directed corner requests, then
// runs biased fill/drain random traffic under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_bounded_stack_with_remove_at;
  import bstk_pkg::*;

  localparam int Depth = DepthDefault;
  localparam int ClkHalf = 10;
  localparam int DrainCycles = 40;
  localparam int PhaseItems = 156;
  // Unused operation code: the block answers it with ok and no change
  localparam logic [OpW-1:0] OpIgnored = 2'd3;

  typedef struct packed {
    logic [ValueW-1:0] removed_value;
    logic [StatW-1:0]  status;
    logic              is_full;
    logic              is_empty;
    logic [CountW-1:0] count;
  } stack_rsp_t;

  // Shadow stack and queue of responses still owed by the block
  class stack_scoreboard;
    logic [ValueW-1:0] slots[Depth];
    int unsigned       fill;
    stack_rsp_t        owed_rsp[$];
    int unsigned       mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    function int unsigned outstanding();
      return owed_rsp.size();
    endfunction

    task report(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatches++;
    endtask

    // Apply one accepted request to the shadow stack and queue its response
    function void note_request(input logic [OpW-1:0] op, input logic [ValueW-1:0] val,
                               input logic [PosW-1:0] pos);
      stack_rsp_t  rsp;
      int unsigned i;
      rsp = '0;
      rsp.status = StOk;
      case (op)
        OpPush: begin
          if (fill >= Depth) begin
            rsp.status = StOverflow;
          end else begin
            slots[fill] = val;
            fill++;
          end
        end
        OpPop: begin
          if (fill == 0) begin
            rsp.status = StUnderflow;
          end else begin
            fill--;
            rsp.removed_value = slots[fill];
          end
        end
        OpRemove: begin
          if (fill == 0) begin
            rsp.status = StUnderflow;
          end else if (pos == 0 || pos > fill) begin
            rsp.status = StBadPos;
          end else begin
            rsp.removed_value = slots[pos-1];
            // close the gap
            for (i = pos; i < fill; i++) slots[i-1] = slots[i];
            fill--;
          end
        end
        default: ;
      endcase
      rsp.is_full  = (fill == Depth);
      rsp.is_empty = (fill == 0);
      rsp.count    = fill[CountW-1:0];
      owed_rsp.push_back(rsp);
    endfunction

    // Compare one accepted response with the oldest owed one
    task check_response(input stack_rsp_t got);
      stack_rsp_t want;
      if (owed_rsp.size() == 0) begin
        report("response with no request outstanding");
      end else begin
        want = owed_rsp.pop_front();
        if (got.removed_value !== want.removed_value)
          report($sformatf("removed_value %h, want %h", got.removed_value,
                           want.removed_value));
        if (got.status !== want.status)
          report($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.is_full !== want.is_full)
          report($sformatf("is_full %b, want %b", got.is_full, want.is_full));
        if (got.is_empty !== want.is_empty)
          report($sformatf("is_empty %b, want %b", got.is_empty, want.is_empty));
        if (got.count !== want.count)
          report($sformatf("count %0d, want %0d", got.count, want.count));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  int unsigned idle_pct;
  int unsigned stall_pct;
  bit filling;
  stack_rsp_t seen_rsp;
  stack_scoreboard stack_sb;

  bstk_req_if req_if ();
  bstk_rsp_if rsp_if ();

  bounded_stack_with_remove_at #(
    .DEPTH(Depth)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #ClkHalf clk_i = ~clk_i;
  end

  // Stop a hung run
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Stall the response side at the phase rate
  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Check every accepted response
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      seen_rsp.removed_value = rsp_if.removed_value;
      seen_rsp.status        = rsp_if.status;
      seen_rsp.is_full       = rsp_if.is_full;
      seen_rsp.is_empty      = rsp_if.is_empty;
      seen_rsp.count         = rsp_if.count;
      stack_sb.check_response(seen_rsp);
    end
  end

  // Offer one request, idling first at the phase rate; hold until accepted
  task automatic send_request(input logic [OpW-1:0] op, input logic [ValueW-1:0] val,
                              input logic [PosW-1:0] pos);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.value     <= val;
    req_if.position  <= pos;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    stack_sb.note_request(op, val, pos);
  endtask

  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Random traffic that swings between filling and draining the stack
  task automatic run_random(input int unsigned n);
    int unsigned k;
    int unsigned r;
    int unsigned cnt;
    logic [OpW-1:0] op;
    logic [PosW-1:0] pos;
    for (k = 0; k < n; k++) begin
      cnt = stack_sb.fill;
      if (cnt == Depth && $urandom_range(9) < 7) filling = 1'b0;
      if (cnt == 0 && $urandom_range(9) < 7) filling = 1'b1;
      r = $urandom_range(99);
      if (filling) begin
        op = (r < 65) ? OpPush : (r < 75) ? OpPop : (r < 95) ? OpRemove : OpIgnored;
      end else begin
        op = (r < 15) ? OpPush : (r < 55) ? OpPop : (r < 95) ? OpRemove : OpIgnored;
      end
      pos = PosW'($urandom());
      if (op == OpRemove) begin
        r = $urandom_range(9);
        if (r < 7 && cnt > 0) pos = PosW'($urandom_range(cnt, 1));
        else if (r == 7) pos = '0;
        else if (r == 8) pos = PosW'($urandom_range(31, cnt + 1));
      end
      send_request(op, pick_value(), pos);
    end
  endtask

  // Main sequence
  initial begin
    int unsigned k;
    int unsigned ph;
    stack_sb = new();
    rst_ni <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.operation <= OpPush;
    req_if.value     <= '0;
    req_if.position  <= '0;
    idle_pct  = 0;
    stall_pct = 0;
    filling   = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty cases, fill to full with extreme words, edge positions
    send_request(OpPop, 32'h1234_5678, 5'd0);
    send_request(OpRemove, '0, 5'd1);
    send_request(OpIgnored, 32'hFFFF_FFFF, 5'd31);
    send_request(OpPush, 32'h7FFF_FFFF, 5'd0);
    send_request(OpPush, 32'h8000_0000, 5'd0);
    send_request(OpPush, 32'hFFFF_FFFF, 5'd0);
    send_request(OpPush, 32'h0000_0000, 5'd0);
    for (k = 4; k < Depth; k++) send_request(OpPush, 32'hA5A5_0000 | k, 5'd0);
    send_request(OpPush, 32'h5A5A_5A5A, 5'd0);
    send_request(OpIgnored, '0, 5'd0);
    send_request(OpRemove, '0, 5'd0);
    send_request(OpRemove, '0, 5'd17);
    send_request(OpRemove, '0, 5'd1);
    send_request(OpRemove, '0, 5'd15);
    send_request(OpRemove, '0, 5'd7);
    send_request(OpPop, '0, 5'd0);

    // Random phases: none, sender idle, receiver stall, both; twice over
    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 68; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      run_random(PhaseItems);
    end
    req_if.valid <= 1'b0;

    // Drain and let the block settle
    while (stack_sb.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (stack_sb.mismatches == 0 && stack_sb.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: bounded_stack_with_remove_at.f
+incdir+rtl
rtl/bstk_pkg.sv
rtl/bstk_ifs.sv
rtl/bstk_ctrl.sv
rtl/bstk_dpath.sv
rtl/bounded_stack_with_remove_at.sv
rtl/bstk_chk.sv
dv/tb_bounded_stack_with_remove_at.sv
